>>> hw/rtl/idsl_pkg.sv
package idsl_pkg;

  // Number of ink channels the block is built for, and the number of slots
  // the pixel format carries. Only channels below ACT take part.
  localparam int CHANNELS = 4;
  localparam int NSLOTS   = 4;
  localparam int ACT      = (CHANNELS > NSLOTS) ? NSLOTS : CHANNELS;

  localparam int LVL_W  = 16;
  localparam int LIM_W  = 18;
  localparam int PROD_W = 2 * LVL_W;
  localparam int CH_W   = $clog2(NSLOTS);

  localparam logic [LVL_W-1:0]  UNITY = 16'hFFFF;
  localparam logic [PROD_W-1:0] HALF  = 32'd32767;

  localparam logic [NSLOTS-1:0] ACT_MASK = NSLOTS'((1 << ACT) - 1);

  // Limit divider retires two quotient bits per cycle.
  localparam int DIV_STEPS = LVL_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INK_CAP   = 3'd4;

  typedef logic [NSLOTS-1:0][LVL_W-1:0] lvl_vec_t;

  typedef struct packed {
    lvl_vec_t          v;
    logic [LIM_W-1:0]  total;
    logic              limit;
    logic [NSLOTS-1:0] mask;
    logic              last;
  } entry_t;

  typedef struct packed {
    lvl_vec_t          v;
    logic              limited;
    logic [NSLOTS-1:0] mask;
    logic              last;
  } result_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_MUL,
    FS_DIV,
    FS_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_MUL,
    BS_DIV,
    BS_OUT
  } back_state_t;

endpackage

>>> hw/rtl/ink_density_scale_limit_unit.sv
// out_tvalid rises later after a pixel is accepted when the ink cap applies to it
// than when it does not. The front takes a new pixel only once the last one is
// scaled and queued; a capped pixel holds the shared serial divider for all of its
// channels; output stalls hold the back and, through the queue, the front.
// Reset (synchronous, rst_n low) restores unity densities, disables the cap, empties
// the queue and the output register and clears the per-line zero tracking.
module ink_density_scale_limit_unit (
  input  logic         clk,
  input  logic         rst_n,
  // Pixel input. in_tdata fields from bit 0 up: level_0, level_1, level_2,
  // level_3, 16 bits each. in_tlast carries last_pixel.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,
  input  logic         in_tlast,
  // Result output. out_tdata fields from bit 0 up: out_0, out_1, out_2, out_3,
  // 16 bits each. out_tlast carries line_end.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,
  // out_tuser fields from bit 0 up: was_limited (1 bit), zero-channel mask
  // (4 bits), then zero fill.
  output logic [7:0]   out_tuser,
  output logic         out_tlast,
  // Register writes: index 0..3 density_0..density_3, index 4 the ink cap.
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [17:0]  cfg_wdata
);
  import idsl_pkg::*;

  localparam int TUSER_PAD = 8 - 1 - NSLOTS;

  // Configuration registers. The user must write them only while the pipeline is
  // idle; the block does not enforce it. The front and back read them directly.
  lvl_vec_t         density_r;
  logic [LIM_W-1:0] ink_cap_r;

  logic    push_valid, push_ready;
  entry_t  push_entry;
  logic    pop_valid, pop_ready;
  entry_t  pop_entry;
  result_t out_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSLOTS; i++) begin
        density_r[i] <= UNITY;
      end
      ink_cap_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index < CFG_IDX_W'(NSLOTS)) begin
        density_r[cfg_index[CH_W-1:0]] <= cfg_wdata[LVL_W-1:0];
      end else if (cfg_index == CFG_INK_CAP) begin
        ink_cap_r <= cfg_wdata;
      end
    end
  end

  // The front scales each channel by its density with one shared multiplier,
  // one channel at a time (multiply, then divide), and tracks which channels
  // stayed at zero on the current line. It also decides if the ink limit applies.
  idsl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_level   (in_tdata),
    .in_last    (in_tlast),
    .density    (density_r),
    .ink_cap    (ink_cap_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // A short queue lets the front keep scaling while the back is busy in the
  // limit divider or waiting on a stalled output.
  idsl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // The back applies the ink limit through one serial divider shared by all
  // channels and holds the finished result in the output register.
  idsl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry),
    .ink_cap    (ink_cap_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = out_result.v;
  assign out_tuser = {{TUSER_PAD{1'b0}}, out_result.mask, out_result.limited};
  assign out_tlast = out_result.last;

endmodule

>>> hw/rtl/idsl_front.sv
module idsl_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  idsl_pkg::lvl_vec_t            in_level,
  input  logic                          in_last,
  input  idsl_pkg::lvl_vec_t            density,
  input  logic [idsl_pkg::LIM_W-1:0]    ink_cap,
  output logic                          push_valid,
  input  logic                          push_ready,
  output idsl_pkg::entry_t              push_entry
);
  import idsl_pkg::*;

  front_state_t      state_r, state_nxt;
  logic [CH_W-1:0]   ch_r;
  lvl_vec_t          lvl_r;
  logic              last_r;
  logic [PROD_W-1:0] prod_r;
  lvl_vec_t          v_r;
  logic [LIM_W-1:0]  total_r;
  logic [NSLOTS-1:0] seen_r;

  logic [LVL_W-1:0]  q0;
  logic [LVL_W:0]    rsum;
  logic [LVL_W-1:0]  quot;
  logic [LVL_W-1:0]  scaled;
  logic [LVL_W-1:0]  dsel;
  logic [LIM_W-1:0]  dens_sum;
  logic              ch_last;
  logic              limit;

  // Division by 65535: x = q0*65535 + (q0 + lo), and that remainder stays
  // below twice the divisor, so one correction suffices.
  always_comb begin
    dsel    = density[ch_r];
    q0      = prod_r[PROD_W-1:LVL_W];
    rsum    = {1'b0, q0} + {1'b0, prod_r[LVL_W-1:0]};
    quot    = q0 + LVL_W'(rsum >= {1'b0, UNITY});
    if (dsel == '0) begin
      scaled = '0;
    end else if (dsel == UNITY) begin
      scaled = lvl_r[ch_r];
    end else begin
      scaled = quot;
    end
    ch_last = (ch_r == CH_W'(ACT - 1));
  end

  always_comb begin
    dens_sum = '0;
    for (int i = 0; i < ACT; i++) begin
      dens_sum = dens_sum + LIM_W'(density[i]);
    end
    limit = (ink_cap != '0) && (ink_cap < dens_sum) && (total_r > ink_cap);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE: begin
        if (in_valid) state_nxt = FS_MUL;
      end
      FS_MUL:  state_nxt = FS_DIV;
      FS_DIV: begin
        state_nxt = ch_last ? FS_PUSH : FS_MUL;
      end
      FS_PUSH: begin
        if (push_ready) state_nxt = FS_IDLE;
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = (state_r == FS_IDLE);
    push_valid       = (state_r == FS_PUSH);
    push_entry.v     = v_r;
    push_entry.total = total_r;
    push_entry.limit = limit;
    push_entry.mask  = ~seen_r & ACT_MASK;
    push_entry.last  = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      seen_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == FS_DIV && scaled != '0) begin
        seen_r[ch_r] <= 1'b1;
      end
      if (state_r == FS_PUSH && push_ready && last_r) begin
        seen_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      FS_IDLE: begin
        if (in_valid) begin
          lvl_r   <= in_level;
          last_r  <= in_last;
          v_r     <= '0;
          total_r <= '0;
          ch_r    <= '0;
        end
      end
      FS_MUL: begin
        prod_r <= PROD_W'(lvl_r[ch_r]) * PROD_W'(dsel) + HALF;
      end
      FS_DIV: begin
        v_r[ch_r] <= scaled;
        total_r   <= total_r + LIM_W'(scaled);
        if (!ch_last) ch_r <= ch_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FS_PUSH) |-> ch_last)
    else $error("front pushed a pixel before all channels were scaled");

endmodule

>>> hw/rtl/idsl_queue.sv
module idsl_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  idsl_pkg::entry_t  push_entry,
  output logic              pop_valid,
  input  logic              pop_ready,
  output idsl_pkg::entry_t  pop_entry
);
  import idsl_pkg::*;

  entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue occupancy above its depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree while empty");

endmodule

>>> hw/rtl/idsl_back.sv
module idsl_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  idsl_pkg::entry_t            pop_entry,
  input  logic [idsl_pkg::LIM_W-1:0]  ink_cap,
  output logic                        out_valid,
  input  logic                        out_ready,
  output idsl_pkg::result_t           out_result
);
  import idsl_pkg::*;

  back_state_t       state_r, state_nxt;
  entry_t            ent_r;
  lvl_vec_t          v_r;
  logic [CH_W-1:0]   ch_r;
  logic [STEP_W-1:0] step_r;
  logic [LIM_W-1:0]  rem_r;
  logic [LVL_W-1:0]  num_r;
  logic [LVL_W-1:0]  quo_r;
  logic              out_valid_r;
  result_t           res_r;

  logic [LIM_W+LVL_W-1:0] prod;
  logic [LIM_W:0]    r1, r1s, r2, r2s;
  logic              b1, b2;
  logic              slot_free;
  logic              load_out;
  logic              ch_last;
  logic              step_last;

  // Restoring division, two quotient bits per cycle. The quotient is known to
  // fit in 16 bits because the limit is below the total.
  always_comb begin
    prod      = (LIM_W+LVL_W)'(ent_r.v[ch_r]) * (LIM_W+LVL_W)'(ink_cap);
    r1        = {rem_r, num_r[LVL_W-1]};
    b1        = (r1 >= {1'b0, ent_r.total});
    r1s       = b1 ? r1 - {1'b0, ent_r.total} : r1;
    r2        = {r1s[LIM_W-1:0], num_r[LVL_W-2]};
    b2        = (r2 >= {1'b0, ent_r.total});
    r2s       = b2 ? r2 - {1'b0, ent_r.total} : r2;
    ch_last   = (ch_r == CH_W'(ACT - 1));
    step_last = (step_r == STEP_W'(DIV_STEPS - 1));
    slot_free = !out_valid_r || out_ready;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_IDLE: begin
        if (pop_valid) state_nxt = pop_entry.limit ? BS_MUL : BS_OUT;
      end
      BS_MUL:  state_nxt = BS_DIV;
      BS_DIV: begin
        if (step_last) state_nxt = ch_last ? BS_OUT : BS_MUL;
      end
      BS_OUT: begin
        if (slot_free) state_nxt = BS_IDLE;
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = (state_r == BS_IDLE);
    load_out  = (state_r == BS_OUT) && slot_free;
  end

  assign out_valid  = out_valid_r;
  assign out_result = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BS_IDLE: begin
        if (pop_valid) begin
          ent_r <= pop_entry;
          v_r   <= pop_entry.v;
          ch_r  <= '0;
        end
      end
      BS_MUL: begin
        rem_r  <= prod[LIM_W+LVL_W-1:LVL_W];
        num_r  <= prod[LVL_W-1:0];
        step_r <= '0;
      end
      BS_DIV: begin
        rem_r  <= r2s[LIM_W-1:0];
        num_r  <= {num_r[LVL_W-3:0], 2'b00};
        quo_r  <= {quo_r[LVL_W-3:0], b1, b2};
        step_r <= step_r + 1'b1;
        if (step_last) begin
          v_r[ch_r] <= {quo_r[LVL_W-3:0], b1, b2};
          if (!ch_last) ch_r <= ch_r + 1'b1;
        end
      end
      BS_OUT: begin
        if (slot_free) begin
          res_r.v       <= v_r;
          res_r.limited <= ent_r.limit;
          res_r.mask    <= ent_r.mask;
          res_r.last    <= ent_r.last;
        end
      end
      default: begin
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_DIV) |-> (ink_cap < ent_r.total))
    else $error("limit divider running on a pixel within the limit");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_DIV) |-> (rem_r < ent_r.total))
    else $error("divider remainder not below the divisor");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import idsl_pkg::*;

  // Scoreboard: keeps its own copy of the density and ink limit registers
  // and of the per-line zero tracking, predicts every accepted pixel and
  // checks the results in order against those predictions.
  class ink_scoreboard;
    logic [LVL_W-1:0]  density [NSLOTS];
    logic [LIM_W-1:0]  ink_cap;
    logic [NSLOTS-1:0] seen_nonzero;
    result_t           pending_pixels[$];
    int unsigned       fail_count;
    int unsigned       checked_count;
    int unsigned       limited_count;
    int unsigned       line_count;

    function new();
      for (int i = 0; i < NSLOTS; i++) density[i] = UNITY;
      ink_cap       = '0;
      seen_nonzero  = '0;
      fail_count    = 0;
      checked_count = 0;
      limited_count = 0;
      line_count    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [LIM_W-1:0] value);
      if (index < CFG_IDX_W'(NSLOTS)) density[index[CH_W-1:0]] = value[LVL_W-1:0];
      else if (index == CFG_INK_CAP) ink_cap = value;
    endfunction

    // Scale, track zero channels, then apply the total ink limit.
    function void note_pixel(lvl_vec_t levels, logic last);
      result_t         r;
      longint unsigned scaled;
      longint unsigned total;
      longint unsigned density_sum;
      r = '0;
      total = 0;
      density_sum = 0;
      for (int i = 0; i < NSLOTS; i++) begin
        if (i < ACT) begin
          if (density[i] == '0) scaled = 0;
          else if (density[i] == UNITY) scaled = 64'(levels[i]);
          else scaled = (64'(levels[i]) * 64'(density[i]) + 64'(HALF)) / 64'(UNITY);
          r.v[i] = scaled[LVL_W-1:0];
          if (scaled != 0) seen_nonzero[i] = 1'b1;
          total += scaled;
          density_sum += 64'(density[i]);
        end
      end
      // The mask reflects the scaled values before any limiting.
      for (int i = 0; i < ACT; i++) r.mask[i] = ~seen_nonzero[i];
      if (ink_cap != '0 && 64'(ink_cap) < density_sum && total > 64'(ink_cap)) begin
        for (int i = 0; i < ACT; i++)
          r.v[i] = LVL_W'((64'(r.v[i]) * 64'(ink_cap)) / total);
        r.limited = 1'b1;
      end
      r.last = last;
      if (last) seen_nonzero = '0;
      pending_pixels.push_back(r);
    endfunction

    task report(string msg);
      fail_count++;
      if (fail_count <= 40) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_pixel(logic [63:0] data, logic [7:0] user, logic last);
      result_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("result beat with no pixel pending, tdata %h", data));
        return;
      end
      want = pending_pixels.pop_front();
      checked_count++;
      if (want.limited) limited_count++;
      if (want.last) line_count++;
      for (int i = 0; i < NSLOTS; i++)
        if (data[LVL_W*i +: LVL_W] !== want.v[i])
          report($sformatf("pixel %0d channel %0d: got %h, want %h", checked_count - 1,
                           i, data[LVL_W*i +: LVL_W], want.v[i]));
      if (user[0] !== want.limited)
        report($sformatf("pixel %0d was_limited: got %b, want %b", checked_count - 1,
                         user[0], want.limited));
      if (user[NSLOTS:1] !== want.mask)
        report($sformatf("pixel %0d zero mask: got %b, want %b", checked_count - 1,
                         user[NSLOTS:1], want.mask));
      if (user[7:NSLOTS+1] !== '0)
        report($sformatf("pixel %0d tuser fill bits not zero: %b", checked_count - 1,
                         user));
      if (last !== want.last)
        report($sformatf("pixel %0d line_end: got %b, want %b", checked_count - 1,
                         last, want.last));
    endtask
  endclass

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_INK_CAP + 1'b1;
  localparam logic [LIM_W-1:0]     LIMIT_ALL_ONES   = '1;

  // All block inputs start at known values before the first edge.
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [7:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = '0;
  logic [17:0] cfg_wdata  = '0;

  ink_scoreboard sb = new();

  int unsigned burst_left  = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_mode  = 0;
  int unsigned cfg_writes  = 0;
  logic [NSLOTS-1:0] quiet_channels = '0;

  ink_density_scale_limit_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every result beat is checked at the rising edge where it is accepted.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(out_tdata, out_tuser, out_tlast);
  end

  // The receiver runs its own stall pattern, independent of the sender. It
  // switches among always ready, coin-flip stalls, mostly stalled, and a
  // periodic stall pattern, each for a random stretch.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: begin
        out_tready = 1'b1;
      end
      1: begin
        out_tready = 1'($urandom_range(0, 1));
      end
      2: begin
        out_tready = ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_tready = ((stall_left % 16) < 4);
      end
    endcase
  end

  // Drives one pixel beat. The sender works in bursts: at the start of a
  // burst it drops tvalid for a random gap. Within a burst tvalid stays high
  // from one beat to the next, so it is never lowered and raised in one step.
  task send_pixel(input lvl_vec_t levels, input logic last);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3))
        @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tdata  = levels;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(levels, last);
    @(negedge clk);
  endtask

  // Stops the sender and waits until every predicted result has been seen.
  // Register writes happen only after this, with the block idle.
  task wait_idle();
    in_tvalid = 1'b0;
    burst_left = 0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task write_reg(input logic [CFG_IDX_W-1:0] index, input logic [LIM_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_wdata = value;
    sb.write_reg(index, value);
    cfg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task set_config(input logic [LVL_W-1:0] d0, input logic [LVL_W-1:0] d1,
                  input logic [LVL_W-1:0] d2, input logic [LVL_W-1:0] d3,
                  input logic [LIM_W-1:0] limit);
    wait_idle();
    write_reg(CFG_DENSITY_0, LIM_W'(d0));
    write_reg(CFG_DENSITY_1, LIM_W'(d1));
    write_reg(CFG_DENSITY_2, LIM_W'(d2));
    write_reg(CFG_DENSITY_3, LIM_W'(d3));
    write_reg(CFG_INK_CAP, limit);
  endtask

  function automatic lvl_vec_t mk_pixel(logic [LVL_W-1:0] l0, logic [LVL_W-1:0] l1,
                                        logic [LVL_W-1:0] l2, logic [LVL_W-1:0] l3);
    lvl_vec_t p;
    p[0] = l0;
    p[1] = l1;
    p[2] = l2;
    p[3] = l3;
    return p;
  endfunction

  // Densities are drawn with a bias toward the special values: zero, unity,
  // one below unity and one.
  function automatic logic [LVL_W-1:0] pick_density();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return UNITY;
      2: return UNITY - 1'b1;
      3: return 16'd1;
      default: return LVL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Levels: zero, full, small and uniform values. Channels marked quiet for
  // the current line stay at zero so that zero mask bits survive to the end.
  function automatic lvl_vec_t pick_levels(logic [NSLOTS-1:0] quiet);
    lvl_vec_t p;
    for (int i = 0; i < NSLOTS; i++) begin
      case ($urandom_range(0, 6))
        0: p[i] = '0;
        1: p[i] = '1;
        2: p[i] = LVL_W'($urandom_range(1, 255));
        default: p[i] = LVL_W'($urandom_range(0, 65535));
      endcase
      if (quiet[i]) p[i] = '0;
    end
    return p;
  endfunction

  initial begin
    logic [LVL_W-1:0] d [NSLOTS];
    logic [LIM_W-1:0] limit;
    int unsigned      density_sum;
    logic             last;

    // Synchronous reset held, then released once.
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part. First the reset settings: unity densities, no limit.
    // A line with a channel that stays zero, then line end clearing the mask.
    send_pixel(mk_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0);
    send_pixel(mk_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h0000), 1'b1);
    send_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
    send_pixel(mk_pixel(16'h0001, 16'h8000, 16'h7FFF, 16'h5555), 1'b1);

    // Density extremes per channel: zero, unity, one and one below unity.
    // Rounding of the scaled value shows on the small levels.
    set_config(16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 18'd0);
    send_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
    send_pixel(mk_pixel(16'h0001, 16'h0001, 16'h0001, 16'h0001), 1'b0);
    send_pixel(mk_pixel(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF), 1'b1);

    // Limit active: total above, at and below the limit. Halves round down.
    set_config(UNITY, UNITY, UNITY, UNITY, 18'd65535);
    send_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000), 1'b0);
    send_pixel(mk_pixel(16'h4000, 16'h4000, 16'h4000, 16'h4000), 1'b0);
    send_pixel(mk_pixel(16'h3FFF, 16'h3FFF, 16'h3FFF, 16'h3FFF), 1'b0);
    send_pixel(mk_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h0000), 1'b1);

    // Smallest limit: a total at the limit passes, a total above it is driven to zero after the mask is taken.
    wait_idle();
    write_reg(CFG_INK_CAP, 18'd1);
    send_pixel(mk_pixel(16'h0001, 16'h0000, 16'h0000, 16'h0000), 1'b0);
    send_pixel(mk_pixel(16'h0001, 16'h0001, 16'h0000, 16'h0000), 1'b1);

    // Limit one below the density sum, equal to it (disabled), and the
    // all-ones value beyond the documented range (disabled as well).
    wait_idle();
    write_reg(CFG_INK_CAP, 18'd262139);
    send_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
    wait_idle();
    write_reg(CFG_INK_CAP, 18'd262140);
    send_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
    wait_idle();
    write_reg(CFG_INK_CAP, LIMIT_ALL_ONES);
    send_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1);

    // Reduced densities with a limit under their sum.
    set_config(16'h4000, 16'h4000, 16'h4000, 16'h4000, 18'd40000);
    send_pixel(mk_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);

    // Writes to the unused register indexes must change nothing.
    wait_idle();
    for (int idx = CFG_FIRST_UNUSED; idx < (1 << CFG_IDX_W); idx++)
      write_reg(CFG_IDX_W'(idx), LIM_W'($urandom_range(0, 262143)));
    send_pixel(mk_pixel(16'h1234, 16'hABCD, 16'h0F0F, 16'hF0F0), 1'b1);

    // Random part: ten phases with fresh register settings. The first phase
    // keeps unity densities; the limit choice is biased toward values that
    // actually engage limiting, plus its disabled and boundary values.
    for (int phase = 0; phase < 10; phase++) begin
      density_sum = 0;
      for (int i = 0; i < NSLOTS; i++) begin
        d[i] = (phase == 0) ? UNITY : pick_density();
        if (i < ACT) density_sum += 32'(d[i]);
      end
      case ($urandom_range(0, 5))
        0: limit = '0;
        1: limit = LIM_W'($urandom_range(1, 2000));
        2: limit = (density_sum > 0) ? LIM_W'($urandom_range(1, density_sum)) : 18'd1;
        3: limit = LIM_W'(density_sum);
        4: limit = LIMIT_ALL_ONES;
        default: limit = LIM_W'($urandom_range(0, 262143));
      endcase
      set_config(d[0], d[1], d[2], d[3], limit);

      for (int n = 0; n < 175; n++) begin
        // Let the pipeline drain completely once in a while mid-phase.
        if (n == 80 && phase % 2 == 0) wait_idle();
        last = ($urandom_range(0, 9) == 0);
        send_pixel(pick_levels(quiet_channels), last);
        if (last)
          quiet_channels = ($urandom_range(0, 1) == 0) ? NSLOTS'($urandom_range(0, 15)) : '0;
      end
    end

    // Drain, then keep the clock running for stray beats.
    wait_idle();
    repeat (150) @(posedge clk);

    $display("Summary: %0d pixels checked, %0d of them limited, %0d line ends, %0d register writes",
             sb.checked_count, sb.limited_count, sb.line_count, cfg_writes);
    $display("Stimulus covered density extremes, disabled and boundary ink limits, and stalls on both sides.");
    if (sb.fail_count == 0 && sb.pending_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.fail_count,
               sb.pending_pixels.size());
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #10_000_000;
    $display("Timeout: the run did not complete in time");
    $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/idsl_pkg.sv
hw/rtl/idsl_front.sv
hw/rtl/idsl_queue.sv
hw/rtl/idsl_back.sv
hw/rtl/ink_density_scale_limit_unit.sv
tb/sv/tb.sv
